// ===== hw/rtl/tacm_pkg.sv =====
package tacm_pkg;

	typedef logic [3:0] nibble_t;
	typedef logic [7:0] attr_t;
	typedef logic [2:0] cfg_index_t;
	typedef logic [31:0] cfg_word_t;

	localparam cfg_index_t REG_PALETTE_LOW  = 3'd0;
	localparam cfg_index_t REG_PALETTE_HIGH = 3'd1;
	localparam cfg_index_t REG_SIMPLE_W0    = 3'd2;
	localparam cfg_index_t REG_SIMPLE_W1    = 3'd3;
	localparam cfg_index_t REG_SIMPLE_W2    = 3'd4;
	localparam cfg_index_t REG_SIMPLE_W3    = 3'd5;
	localparam cfg_index_t REG_MONO_ENABLE  = 3'd6;

	localparam cfg_word_t RST_PALETTE_LOW  = 32'h0751_FFFE;
	localparam cfg_word_t RST_PALETTE_HIGH = 32'hFE98_CBAC;
	localparam cfg_word_t RST_SIMPLE_W0    = 32'h5150_4140;
	localparam cfg_word_t RST_SIMPLE_W1    = 32'h4342_5848;
	localparam cfg_word_t RST_SIMPLE_W2    = 32'h5A59_4A49;
	localparam cfg_word_t RST_SIMPLE_W3    = 32'h764C_5B4B;

	localparam nibble_t MONO_DIM    = 4'h7;
	localparam nibble_t MONO_BRIGHT = 4'hF;

	// fixed simple table used in mono mode
	function automatic attr_t mono_entry(input nibble_t idx);
		attr_t e;
		case (idx)
			4'd0: e = 8'h70;
			4'd1: e = 8'hF0;
			4'd2: e = 8'h07;
			4'd3: e = 8'h07;
			4'd4: e = 8'hF0;
			4'd5: e = 8'h07;
			default: e = 8'hF0;
		endcase
		return e;
	endfunction

	function automatic nibble_t palette_lookup(input logic [63:0] pal, input nibble_t k);
		return pal[{k, 2'b00} +: 4];
	endfunction

	function automatic attr_t simple_lookup(input logic [127:0] smap, input nibble_t i);
		return smap[{i, 3'b000} +: 8];
	endfunction

endpackage

// ===== hw/rtl/text_attribute_color_mapper.sv =====
// Text attribute to attribute byte mapper.
// The accepting edge (start && !busy) loads the input register; the result register drives the done strobe.
// Throughput: one item per cycle; busy stays low, so start may be held high.
// The palette/simple lookup and mono reduction sit between the input register
// and the result register. The receiver cannot stall: done lasts one cycle.
// Reset (arst_n low) clears the pipeline valids and loads the default maps.
module text_attribute_color_mapper (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [15:0]            attribute_code,
	output logic                   done,
	output logic [7:0]             attribute_byte,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  tacm_pkg::cfg_index_t   cfg_index,
	input  tacm_pkg::cfg_word_t    cfg_data
);
	import tacm_pkg::*;

	logic [63:0]  palette_q;
	logic [127:0] simple_q;
	logic         mono_q;

	logic         valid_s1;
	logic [15:0]  code_s1;
	logic         valid_s2;
	attr_t        attr_s2;

	nibble_t bg;
	nibble_t fg;
	nibble_t bg_m;
	nibble_t fg_m;
	attr_t   entry;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_q <= {RST_PALETTE_HIGH, RST_PALETTE_LOW};
			simple_q  <= {RST_SIMPLE_W3, RST_SIMPLE_W2, RST_SIMPLE_W1, RST_SIMPLE_W0};
			mono_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PALETTE_LOW:  palette_q[31:0]   <= cfg_data;
				REG_PALETTE_HIGH: palette_q[63:32]  <= cfg_data;
				REG_SIMPLE_W0:    simple_q[31:0]    <= cfg_data;
				REG_SIMPLE_W1:    simple_q[63:32]   <= cfg_data;
				REG_SIMPLE_W2:    simple_q[95:64]   <= cfg_data;
				REG_SIMPLE_W3:    simple_q[127:96]  <= cfg_data;
				REG_MONO_ENABLE:  mono_q            <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		code_s1 <= attribute_code;
		attr_s2 <= {bg_m, fg_m};
	end

	always_comb begin
		entry = mono_q ? mono_entry(code_s1[3:0]) : simple_lookup(simple_q, code_s1[3:0]);
		if (code_s1[15:4] == 12'd0) begin
			if (mono_q) begin
				bg = entry[7:4];
				fg = entry[3:0];
			end else begin
				bg = palette_lookup(palette_q, entry[7:4]);
				fg = palette_lookup(palette_q, entry[3:0]);
			end
		end else if (code_s1[15:8] == 8'd0) begin
			bg = palette_lookup(palette_q, code_s1[7:4]);
			fg = palette_lookup(palette_q, code_s1[3:0]);
		end else begin
			// selector nibble zero: true color taken as is
			bg = (code_s1[7:4] != 4'd0) ? palette_lookup(palette_q, code_s1[15:12])
				: code_s1[15:12];
			fg = (code_s1[3:0] != 4'd0) ? palette_lookup(palette_q, code_s1[11:8])
				: code_s1[11:8];
		end

		bg_m = bg;
		fg_m = fg;
		if (mono_q) begin
			if (fg != 4'd0)
				fg_m = fg[3] ? MONO_BRIGHT : MONO_DIM;
			if (bg > 4'd1) begin
				bg_m = MONO_DIM;
				fg_m = 4'd0;
			end else if (bg == 4'd1) begin
				bg_m = 4'd0;
			end
		end
	end

	assign done           = valid_s2;
	assign attribute_byte = attr_s2;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted item did not complete two cycles later");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("done without an item in stage one");

	a_stage_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> !done)
		else $error("done raised with empty stage one");

endmodule

// ===== bench/tacm_attribute_checker.sv =====
module tacm_attribute_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic [15:0]          attribute_code,
	input  logic                 done,
	input  logic [7:0]           attribute_byte,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  tacm_pkg::cfg_index_t cfg_index,
	input  tacm_pkg::cfg_word_t  cfg_data,
	output int                   mismatches,
	output int                   pending,
	output int                   checked,
	output int                   mono_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import tacm_pkg::*;

	localparam logic [15:0] FIRST_PAIR_CODE  = 16'h0010;
	localparam logic [15:0] FIRST_MIXED_CODE = 16'h0100;
	localparam int          REPORT_LIMIT     = 10;

	// fixed small-code table used while mono is on
	localparam attr_t MONO_TABLE [16] = '{
		8'h70, 8'hF0, 8'h07, 8'h07, 8'hF0, 8'h07, 8'hF0, 8'hF0,
		8'hF0, 8'hF0, 8'hF0, 8'hF0, 8'hF0, 8'hF0, 8'hF0, 8'hF0
	};

	logic [63:0]  palette_bits;
	logic [127:0] simple_bits;
	logic         mono_on;
	attr_t        expected_bytes [$];
	logic [15:0]  expected_codes [$];

	function automatic nibble_t palette_color(input nibble_t k);
		nibble_t c;
		c = palette_bits[k * 4 +: 4];
		return c;
	endfunction

	function automatic attr_t map_attribute(input logic [15:0] code);
		nibble_t bg;
		nibble_t fg;
		attr_t   e;
		if (code < FIRST_PAIR_CODE) begin
			if (mono_on) begin
				e = MONO_TABLE[code[3:0]];
				bg = e[7:4];
				fg = e[3:0];
			end else begin
				e = simple_bits[code[3:0] * 8 +: 8];
				bg = palette_color(e[7:4]);
				fg = palette_color(e[3:0]);
			end
		end else if (code < FIRST_MIXED_CODE) begin
			bg = palette_color(code[7:4]);
			fg = palette_color(code[3:0]);
		end else begin
			// zero selector takes the nibble as a true color
			bg = (code[7:4] != 4'h0) ? palette_color(code[15:12]) : code[15:12];
			fg = (code[3:0] != 4'h0) ? palette_color(code[11:8]) : code[11:8];
		end
		if (mono_on) begin
			if (fg != 4'h0)
				fg = (fg < 4'h8) ? MONO_DIM : MONO_BRIGHT;
			if (bg > 4'h1) begin
				bg = MONO_DIM;
				fg = 4'h0;
			end else if (bg == 4'h1) begin
				bg = 4'h0;
			end
		end
		return {bg, fg};
	endfunction

	assign pending = expected_bytes.size();

	always @(posedge clk or negedge arst_n) begin
		attr_t       want;
		logic [15:0] code;
		if (!arst_n) begin
			palette_bits <= {RST_PALETTE_HIGH, RST_PALETTE_LOW};
			simple_bits  <= {RST_SIMPLE_W3, RST_SIMPLE_W2, RST_SIMPLE_W1, RST_SIMPLE_W0};
			mono_on      <= 1'b0;
			mismatches   <= 0;
			checked      <= 0;
			mono_checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PALETTE_LOW:  palette_bits[31:0]   <= cfg_data;
					REG_PALETTE_HIGH: palette_bits[63:32]  <= cfg_data;
					REG_SIMPLE_W0:    simple_bits[31:0]    <= cfg_data;
					REG_SIMPLE_W1:    simple_bits[63:32]   <= cfg_data;
					REG_SIMPLE_W2:    simple_bits[95:64]   <= cfg_data;
					REG_SIMPLE_W3:    simple_bits[127:96]  <= cfg_data;
					REG_MONO_ENABLE:  mono_on              <= cfg_data[0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				expected_bytes.push_back(map_attribute(attribute_code));
				expected_codes.push_back(attribute_code);
				if (mono_on)
					mono_checked <= mono_checked + 1;
			end
			if (done) begin
				if (expected_bytes.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: unexpected attribute_byte %02h with no item pending",
							$realtime, attribute_byte);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_bytes.pop_front();
					code = expected_codes.pop_front();
					checked <= checked + 1;
					if (attribute_byte !== want) begin
						if (mismatches < REPORT_LIMIT)
							$display("%0t: code %04h mono %0b: attribute_byte %02h, expected %02h",
								$realtime, code, mono_on, attribute_byte, want);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

endmodule

// ===== bench/text_attribute_color_mapper_test.sv =====
module text_attribute_color_mapper_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tacm_pkg::*;

	localparam int         PHASES        = 8;
	localparam int         RANDOM_ITEMS  = 230;
	localparam cfg_index_t REG_UNMAPPED  = 3'd7;
	localparam cfg_word_t  WORD_ZEROS    = 32'h0000_0000;
	localparam cfg_word_t  WORD_ONES     = 32'hFFFF_FFFF;
	localparam int         FILL_RANDOM   = 0;
	localparam int         FILL_ZEROS    = 1;
	localparam int         FILL_ONES     = 2;

	localparam cfg_index_t MAP_REGS [6] = '{
		REG_PALETTE_LOW, REG_PALETTE_HIGH,
		REG_SIMPLE_W0, REG_SIMPLE_W1, REG_SIMPLE_W2, REG_SIMPLE_W3
	};

	localparam logic [15:0] DIRECTED_CODES [7] = '{
		16'h0010, 16'h00FF, 16'h0100, 16'hFFFF, 16'hA500, 16'hA50F, 16'hA5F0
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [15:0] attribute_code = '0;
	logic        cfg_valid = 1'b0;
	cfg_index_t  cfg_index = REG_PALETTE_LOW;
	cfg_word_t   cfg_data = '0;
	logic        busy;
	logic        done;
	logic [7:0]  attribute_byte;
	logic        cfg_ready;

	int mismatches;
	int pending;
	int checked;
	int mono_checked;
	int items_sent = 0;
	int cfg_writes = 0;
	int burst_left = 0;

	text_attribute_color_mapper i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.attribute_code (attribute_code),
		.done           (done),
		.attribute_byte (attribute_byte),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	tacm_attribute_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.attribute_code (attribute_code),
		.done           (done),
		.attribute_byte (attribute_byte),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.pending        (pending),
		.checked        (checked),
		.mono_checked   (mono_checked)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("text_attribute_color_mapper verification failed");
		$finish;
	end

	function automatic logic [15:0] random_code();
		logic [7:0] sel;
		case ($urandom_range(0, 4))
			0: return 16'($urandom_range(0, 15));
			1: return 16'($urandom_range(16, 255));
			2: return 16'($urandom);
			default: begin
				sel = 8'($urandom);
				case ($urandom_range(0, 3))
					0: sel = 8'h00;
					1: sel = sel & 8'hF0;
					2: sel = sel & 8'h0F;
					default: ;
				endcase
				return {8'($urandom_range(1, 255)), sel};
			end
		endcase
	endfunction

	function automatic cfg_word_t fill_word(input int fill);
		case (fill)
			FILL_ZEROS:  return WORD_ZEROS;
			FILL_ONES:   return WORD_ONES;
			FILL_RANDOM: return $urandom;
			default:     return $urandom;
		endcase
	endfunction

	task automatic write_reg(input cfg_index_t idx, input cfg_word_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
		@(posedge clk);
	endtask

	// one item per call; start stays high into the next item when no gap follows
	task automatic send_code(input logic [15:0] code, input bit last, input bit steady);
		int gap;
		start          <= 1'b1;
		attribute_code <= code;
		do @(posedge clk); while (busy);
		items_sent++;
		gap = 0;
		if (!steady) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = $urandom_range(1, 7);
			end else begin
				burst_left--;
			end
		end
		if (gap > 0 || last) begin
			start          <= 1'b0;
			attribute_code <= 16'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int fill;
		bit mono;
		bit steady;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				wait_idle();
				fill = phase % 3;
				mono = phase[0];
				foreach (MAP_REGS[r])
					write_reg(MAP_REGS[r], fill_word(fill));
				// bits above bit 0 of the mono register must be ignored
				write_reg(REG_MONO_ENABLE, {fill_word(fill)} & ~32'h1 | 32'(mono));
				if (phase == 3)
					write_reg(REG_UNMAPPED, $urandom);
			end
			steady = (phase == 2);
			if (phase == 0) begin
				for (int c = 0; c < 16; c++)
					send_code(16'(c), 1'b0, 1'b0);
				foreach (DIRECTED_CODES[d])
					send_code(DIRECTED_CODES[d], 1'b0, 1'b0);
			end
			for (int n = 0; n < RANDOM_ITEMS; n++)
				send_code(random_code(), n == RANDOM_ITEMS - 1, steady);
		end

		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Sent %0d attribute codes across %0d register settings (%0d writes).",
			items_sent, PHASES, cfg_writes);
		$display("Compared %0d attribute bytes, %0d of them in mono mode.",
			checked, mono_checked);
		if (mismatches == 0 && pending == 0 && checked == items_sent) begin
			$display("text_attribute_color_mapper verification clean");
		end else begin
			$display("text_attribute_color_mapper verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/tacm_pkg.sv
hw/rtl/text_attribute_color_mapper.sv
bench/tacm_attribute_checker.sv
bench/text_attribute_color_mapper_test.sv
